>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the heater checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define THB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("thb assertion failed");

// Clocked check that also holds while reset is asserted.
`define THB_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
	else $error("thb assertion failed");

`endif

>>> rtl/thb_pkg.sv
// ---------------------------------------------------------------------------
// thb_pkg
// Types, widths and codes shared by the thermistor heater modules.
// ---------------------------------------------------------------------------
package thb_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;

	localparam int unsigned RAW_W  = 14;   // table raw value and sensor sums
	localparam int unsigned TEMP_W = 11;   // table temperature, signed
	localparam int unsigned MAG_W  = 26;   // magnitude of the interpolation numerator
	localparam int unsigned CFG_W  = 16;   // widest configuration register
	localparam int unsigned CFG_AW = 3;

	localparam logic signed [15:0] SETPOINT_RESET = 16'sd25;
	localparam logic [6:0]         ENTRIES_RESET  = 7'd2;

	localparam logic [CFG_AW-1:0] REG_SETPOINT_ONE  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SETPOINT_TWO  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ENABLE_ONE    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ENABLE_TWO    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TABLE_ENTRIES = 3'd4;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0]         raw;
		logic signed [TEMP_W-1:0] temp;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] num_mag;
		logic [RAW_W-1:0] den_mag;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

endpackage

>>> rtl/thb_table_mem.sv
// ---------------------------------------------------------------------------
// thb_table_mem
// Thermistor table store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module thb_table_mem #(
	parameter int unsigned DEPTH = thb_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned AW    = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  thb_pkg::entry_t       wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output thb_pkg::entry_t       rd_data
);

	thb_pkg::entry_t mem [DEPTH];
	thb_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/thb_divider.sv
// ---------------------------------------------------------------------------
// thb_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module thb_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  thb_pkg::div_req_t req,
	output thb_pkg::div_rsp_t rsp
);

	localparam int unsigned MW = thb_pkg::MAG_W;
	localparam int unsigned DW = thb_pkg::RAW_W;
	localparam int unsigned CNTW = $clog2(MW + 1);

	logic [DW-1:0]   rem_q;
	logic [MW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW:0]     trial;
	logic            fits;
	logic [DW:0]     diff;

	always_comb begin
		trial = {rem_q, quo_q[MW-1]};
		fits  = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(MW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num_mag;
			den_q <= req.den_mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[MW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

>>> rtl/thermistor_bang_bang_heater.sv
// Sequence: a table write gives no beat; a tick walks the table once per sensor,
//   multiplies and divides when the sum falls inside a segment, then gives its beat.
// Throughput: one item at a time; a tick holds the input until its beat is loaded,
//   a hold set by the single table read port walked once per sensor
//   and the bit-serial divider; a stalled output beat adds its stall on top.
// Reset: arst_n returns control state and configuration to their reset values; the table is not cleared.
// ---------------------------------------------------------------------------
// thermistor_bang_bang_heater
// Two-channel on/off heater thermostat with a shared thermistor lookup table.
// ---------------------------------------------------------------------------
module thermistor_bang_bang_heater #(
	parameter int unsigned TABLE_DEPTH = thb_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [thb_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [thb_pkg::CFG_W-1:0]         cfg_wdata,

	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [5:0]                        entry_index,
	input  logic [thb_pkg::RAW_W-1:0]         entry_raw,
	input  logic signed [thb_pkg::TEMP_W-1:0] entry_temp,
	input  logic [thb_pkg::RAW_W-1:0]         sensor_sum_one,
	input  logic [thb_pkg::RAW_W-1:0]         sensor_sum_two,

	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [7:0]                 temp_one,
	output logic signed [7:0]                 temp_two,
	output logic                              drive_one,
	output logic                              drive_two,
	output logic                              reached_one,
	output logic                              reached_two
);

	localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	// widths wide enough to hold TABLE_DEPTH itself for the range checks
	localparam int unsigned CW   = (IDXW + 1 > 7) ? IDXW + 1 : 7;
	localparam int unsigned WCW  = (IDXW + 1 > 6) ? IDXW + 1 : 6;
	localparam int unsigned RW   = thb_pkg::RAW_W;
	localparam int unsigned TW   = thb_pkg::TEMP_W;
	localparam int unsigned MW   = thb_pkg::MAG_W;
	localparam int unsigned NW   = MW + 1;     // signed numerator
	localparam int unsigned DNW  = RW + 1;     // signed raw difference
	localparam int unsigned BW   = TW + 1;     // signed temperature difference

	// -----------------------------------------------------------------------
	// Saturation helpers
	// -----------------------------------------------------------------------
	function automatic logic signed [7:0] sat_temp(input logic signed [TW-1:0] t);
		logic signed [7:0] r;
		begin
			if (t > TW'(127)) begin
				r = 8'sd127;
			end else if (t < -TW'(128)) begin
				r = -8'sd128;
			end else begin
				r = t[7:0];
			end
			return r;
		end
	endfunction

	// truncated quotient, sign applied afterwards so it rounds toward zero
	function automatic logic signed [7:0] sat_quot(input logic neg, input logic [MW-1:0] q);
		logic signed [7:0] r;
		begin
			if (!neg) begin
				r = (q > MW'(127)) ? 8'sd127 : q[7:0];
			end else begin
				r = (q > MW'(128)) ? -8'sd128 : 8'(~q[7:0] + 8'd1);
			end
			return r;
		end
	endfunction

	// -----------------------------------------------------------------------
	// Configuration registers
	// -----------------------------------------------------------------------
	logic signed [15:0] setpoint_one_q;
	logic signed [15:0] setpoint_two_q;
	logic               enable_one_q;
	logic               enable_two_q;
	logic [6:0]         table_entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_one_q  <= thb_pkg::SETPOINT_RESET;
			setpoint_two_q  <= thb_pkg::SETPOINT_RESET;
			enable_one_q    <= 1'b0;
			enable_two_q    <= 1'b0;
			table_entries_q <= thb_pkg::ENTRIES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				thb_pkg::REG_SETPOINT_ONE:  setpoint_one_q  <= cfg_wdata;
				thb_pkg::REG_SETPOINT_TWO:  setpoint_two_q  <= cfg_wdata;
				thb_pkg::REG_ENABLE_ONE:    enable_one_q    <= cfg_wdata[0];
				thb_pkg::REG_ENABLE_TWO:    enable_two_q    <= cfg_wdata[0];
				thb_pkg::REG_TABLE_ENTRIES: table_entries_q <= cfg_wdata[6:0];
				default: ;  // writes to unused indexes are dropped
			endcase
		end
	end

	// Clamp the entry count to 2..TABLE_DEPTH and derive the last index walked.
	logic [CW-1:0]   n_ext;
	logic [CW-1:0]   n_clamp;
	logic [CW-1:0]   n_last_ext;
	logic [IDXW-1:0] n_last;

	always_comb begin
		n_ext   = CW'(table_entries_q);
		n_clamp = n_ext;
		if (n_ext < CW'(2)) begin
			n_clamp = CW'(2);
		end else if (n_ext > CW'(TABLE_DEPTH)) begin
			n_clamp = CW'(TABLE_DEPTH);
		end
		n_last_ext = n_clamp - CW'(1);
		n_last     = n_last_ext[IDXW-1:0];
	end

	// -----------------------------------------------------------------------
	// Input handshake and table writes
	// -----------------------------------------------------------------------
	thb_pkg::state_t state_q;
	thb_pkg::state_t state_d;

	logic            in_accept;
	logic [WCW-1:0]  wr_idx_ext;
	logic            wr_en;
	thb_pkg::entry_t wr_data;

	assign in_stall   = (state_q != thb_pkg::ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign wr_idx_ext = WCW'(entry_index);
	// writes beyond the table depth are dropped
	assign wr_en      = in_accept && (kind == thb_pkg::KIND_WRITE)
	                    && (wr_idx_ext < WCW'(TABLE_DEPTH));
	assign wr_data    = '{raw: entry_raw, temp: entry_temp};

	// -----------------------------------------------------------------------
	// Table memory: written by table beats, streamed by the scan
	// -----------------------------------------------------------------------
	logic            rd_en;
	logic [IDXW-1:0] rd_addr_q;
	thb_pkg::entry_t rd_data;

	thb_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IDXW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_ext[IDXW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	// -----------------------------------------------------------------------
	// Conversion datapath
	// -----------------------------------------------------------------------
	logic [RW-1:0]         sum_one_q;
	logic [RW-1:0]         sum_two_q;
	logic                  ch_q;          // 0 converts sensor one, 1 sensor two
	logic                  rd_vld_s1;     // rd_data holds entry rd_idx_s1
	logic [IDXW-1:0]       rd_idx_s1;
	logic [RW-1:0]         prev_raw_q;    // entry i-1
	logic signed [TW-1:0]  prev_temp_q;
	logic signed [TW-1:0]  hi_temp_q;     // entry i
	logic signed [DNW-1:0] den_q;
	logic signed [NW-1:0]  prod_q;
	logic signed [NW-1:0]  part_q;
	logic                  neg_q;
	logic signed [7:0]     temp_one_q;
	logic signed [7:0]     temp_two_q;

	logic [RW-1:0]         sum_cur;
	logic                  hit;
	logic                  last;
	logic                  scan_done;
	logic signed [DNW-1:0] den_d;
	logic                  den_zero;

	always_comb begin
		sum_cur   = ch_q ? sum_two_q : sum_one_q;
		hit       = rd_vld_s1 && (rd_idx_s1 != '0) && (rd_data.raw > sum_cur);
		last      = rd_vld_s1 && (rd_idx_s1 != '0) && !hit && (rd_idx_s1 == n_last);
		scan_done = hit || last;
		den_d     = $signed({1'b0, rd_data.raw}) - $signed({1'b0, prev_raw_q});
		den_zero  = (den_d == '0);
	end

	// One shared multiplier: t0 * den first, then (sum - r0) * (t1 - t0).
	logic signed [DNW-1:0] mul_a;
	logic signed [BW-1:0]  mul_b;
	logic signed [NW-1:0]  mul_p;

	always_comb begin
		if (state_q == thb_pkg::ST_MUL_A) begin
			mul_a = den_q;
			mul_b = BW'(prev_temp_q);
		end else begin
			mul_a = $signed({1'b0, sum_cur}) - $signed({1'b0, prev_raw_q});
			mul_b = BW'(hi_temp_q) - BW'(prev_temp_q);
		end
		mul_p = NW'(mul_a * mul_b);
	end

	// Numerator sum and divider request
	logic signed [NW-1:0] num;
	logic [NW-1:0]        num_abs;
	logic [DNW-1:0]       den_abs;
	thb_pkg::div_req_t    div_req;
	thb_pkg::div_rsp_t    div_rsp;

	always_comb begin
		num             = part_q + prod_q;
		num_abs         = num[NW-1] ? NW'(-num) : NW'(num);
		den_abs         = den_q[DNW-1] ? DNW'(-den_q) : DNW'(den_q);
		div_req.start   = (state_q == thb_pkg::ST_DIV_GO);
		div_req.num_mag = num_abs[MW-1:0];
		div_req.den_mag = den_abs[RW-1:0];
	end

	thb_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// -----------------------------------------------------------------------
	// Sequencer
	// -----------------------------------------------------------------------
	logic              ch_finish;
	logic signed [7:0] ch_result;
	logic              out_load;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		ch_finish = 1'b0;
		ch_result = sat_temp(prev_temp_q);
		out_load  = 1'b0;
		case (state_q)
			thb_pkg::ST_IDLE: begin
				if (in_accept && (kind == thb_pkg::KIND_TICK)) begin
					state_d = thb_pkg::ST_SCAN;
				end
			end
			thb_pkg::ST_SCAN: begin
				// keep issuing reads up to the last entry while the walk goes on
				rd_en = (rd_addr_q <= n_last) && !scan_done;
				if (last) begin
					ch_finish = 1'b1;
					ch_result = sat_temp(rd_data.temp);
				end else if (hit && den_zero) begin
					ch_finish = 1'b1;
					ch_result = sat_temp(prev_temp_q);
				end else if (hit) begin
					state_d = thb_pkg::ST_MUL_A;
				end
			end
			thb_pkg::ST_MUL_A: state_d = thb_pkg::ST_MUL_B;
			thb_pkg::ST_MUL_B: state_d = thb_pkg::ST_DIV_GO;
			thb_pkg::ST_DIV_GO: state_d = thb_pkg::ST_DIV_WAIT;
			thb_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					ch_finish = 1'b1;
					ch_result = sat_quot(neg_q, div_rsp.quot);
				end
			end
			thb_pkg::ST_OUT: begin
				// hold until the output register is free
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = thb_pkg::ST_IDLE;
				end
			end
			default: state_d = thb_pkg::ST_IDLE;
		endcase
		if (ch_finish) begin
			state_d = ch_q ? thb_pkg::ST_OUT : thb_pkg::ST_SCAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= thb_pkg::ST_IDLE;
			ch_q      <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (in_accept) begin
				ch_q      <= 1'b0;
				rd_addr_q <= '0;
			end else if (ch_finish) begin
				// restart the walk from entry 0 for the second sensor
				ch_q      <= 1'b1;
				rd_addr_q <= '0;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + IDXW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sum_one_q <= sensor_sum_one;
			sum_two_q <= sensor_sum_two;
		end
		rd_idx_s1 <= rd_addr_q;
		if (rd_vld_s1 && !hit) begin
			prev_raw_q  <= rd_data.raw;
			prev_temp_q <= rd_data.temp;
		end
		if (hit) begin
			hi_temp_q <= rd_data.temp;
			den_q     <= den_d;
		end
		if ((state_q == thb_pkg::ST_MUL_A) || (state_q == thb_pkg::ST_MUL_B)) begin
			prod_q <= mul_p;
		end
		if (state_q == thb_pkg::ST_MUL_B) begin
			part_q <= prod_q;
		end
		if (state_q == thb_pkg::ST_DIV_GO) begin
			neg_q <= num[NW-1] ^ den_q[DNW-1];
		end
		if (ch_finish && !ch_q) begin
			temp_one_q <= ch_result;
		end
		if (ch_finish && ch_q) begin
			temp_two_q <= ch_result;
		end
	end

	// -----------------------------------------------------------------------
	// Output register: thermostat decision against the saturated temperature
	// -----------------------------------------------------------------------
	logic              out_valid_q;
	logic signed [7:0] temp_one_o_q;
	logic signed [7:0] temp_two_o_q;
	logic              drive_one_q;
	logic              drive_two_q;
	logic              reached_one_q;
	logic              reached_two_q;
	logic              hot_one;
	logic              hot_two;

	assign hot_one = (16'(temp_one_q) >= setpoint_one_q);
	assign hot_two = (16'(temp_two_q) >= setpoint_two_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			temp_one_o_q  <= temp_one_q;
			temp_two_o_q  <= temp_two_q;
			drive_one_q   <= enable_one_q && !hot_one;
			drive_two_q   <= enable_two_q && !hot_two;
			reached_one_q <= enable_one_q && hot_one;
			reached_two_q <= enable_two_q && hot_two;
		end
	end

	assign out_valid   = out_valid_q;
	assign temp_one    = temp_one_o_q;
	assign temp_two    = temp_two_o_q;
	assign drive_one   = drive_one_q;
	assign drive_two   = drive_two_q;
	assign reached_one = reached_one_q;
	assign reached_two = reached_two_q;

endmodule

>>> rtl/thb_checker.sv
// ---------------------------------------------------------------------------
// thb_checker
// Port-level checks on the heater thermostat, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module thb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic kind,
	input logic out_valid,
	input logic out_stall,
	input logic drive_one,
	input logic drive_two,
	input logic reached_one,
	input logic reached_two
);

	`THB_ASSERT_ALWAYS(a_no_beat_in_reset, clk, !arst_n |=> !out_valid)
	`THB_ASSERT(a_out_held, clk, arst_n, out_valid && out_stall |=> out_valid)
	`THB_ASSERT(a_write_silent, clk, arst_n, in_valid && !in_stall && !kind && !out_valid |=> !out_valid)
	`THB_ASSERT(a_tick_not_instant, clk, arst_n, in_valid && !in_stall && kind && !out_valid |=> !out_valid)
	`THB_ASSERT(a_drive_excl, clk, arst_n, out_valid |-> !(drive_one && reached_one) && !(drive_two && reached_two))

endmodule

bind thermistor_bang_bang_heater thb_checker u_thb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.drive_one   (drive_one),
	.drive_two   (drive_two),
	.reached_one (reached_one),
	.reached_two (reached_two)
);

>>> tb/heater_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heater_checker
// Watches the configuration port and both channels of the thermostat, keeps
// its own copy of the table and registers, predicts each tick's status beat
// and compares it field by field with what the block delivers.
// ---------------------------------------------------------------------------
module heater_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [thb_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [thb_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              kind,
	input  logic [5:0]                        entry_index,
	input  logic [thb_pkg::RAW_W-1:0]         entry_raw,
	input  logic signed [thb_pkg::TEMP_W-1:0] entry_temp,
	input  logic [thb_pkg::RAW_W-1:0]         sensor_sum_one,
	input  logic [thb_pkg::RAW_W-1:0]         sensor_sum_two,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [7:0]                 temp_one,
	input  logic signed [7:0]                 temp_two,
	input  logic                              drive_one,
	input  logic                              drive_two,
	input  logic                              reached_one,
	input  logic                              reached_two,
	output int                                fail_count,
	output int                                pending
);

	typedef struct {
		logic signed [7:0] temp_one;
		logic signed [7:0] temp_two;
		logic              drive_one;
		logic              drive_two;
		logic              reached_one;
		logic              reached_two;
	} heater_status_t;

	heater_status_t                    status_due[$];
	logic [thb_pkg::RAW_W-1:0]         curve_raw[thb_pkg::TABLE_DEPTH_DEF];
	logic signed [thb_pkg::TEMP_W-1:0] curve_temp[thb_pkg::TABLE_DEPTH_DEF];
	logic signed [15:0]                target_one, target_two;
	logic                              allow_one, allow_two;
	logic [6:0]                        curve_len;
	int                                n_bad = 0;

	function automatic logic signed [7:0] clamp_byte(input longint v);
		if (v > 127)
			return 8'sd127;
		if (v < -128)
			return -8'sd128;
		return 8'(v);
	endfunction

	// Piecewise-linear lookup over the live part of the curve.
	function automatic logic signed [7:0] sum_to_degrees(input logic [thb_pkg::RAW_W-1:0] sum);
		int                n;
		longint            r0, r1, t0, t1, span, num;
		bit                hit;
		logic signed [7:0] deg;
		n = int'(curve_len);
		if (n < 2)
			n = 2;
		if (n > thb_pkg::TABLE_DEPTH_DEF)
			n = thb_pkg::TABLE_DEPTH_DEF;
		hit = 1'b0;
		deg = clamp_byte(longint'(curve_temp[n-1]));
		for (int i = 1; i < n; i++) begin
			if (!hit && curve_raw[i] > sum) begin
				hit  = 1'b1;
				r0   = longint'(curve_raw[i-1]);
				r1   = longint'(curve_raw[i]);
				t0   = longint'(curve_temp[i-1]);
				t1   = longint'(curve_temp[i]);
				span = r1 - r0;
				if (span == 0) begin
					deg = clamp_byte(t0);
				end else begin
					num = t0 * span + (longint'(sum) - r0) * (t1 - t0);
					deg = clamp_byte(num / span);
				end
			end
		end
		return deg;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_bad++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heater_status_t st;
		heater_status_t seen;
		if (!arst_n) begin
			target_one = thb_pkg::SETPOINT_RESET;
			target_two = thb_pkg::SETPOINT_RESET;
			allow_one  = 1'b0;
			allow_two  = 1'b0;
			curve_len  = thb_pkg::ENTRIES_RESET;
			status_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					thb_pkg::REG_SETPOINT_ONE:  target_one = cfg_wdata;
					thb_pkg::REG_SETPOINT_TWO:  target_two = cfg_wdata;
					thb_pkg::REG_ENABLE_ONE:    allow_one  = cfg_wdata[0];
					thb_pkg::REG_ENABLE_TWO:    allow_two  = cfg_wdata[0];
					thb_pkg::REG_TABLE_ENTRIES: curve_len  = cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (kind == thb_pkg::KIND_WRITE) begin
					curve_raw[entry_index]  = entry_raw;
					curve_temp[entry_index] = entry_temp;
				end else begin
					st.temp_one    = sum_to_degrees(sensor_sum_one);
					st.temp_two    = sum_to_degrees(sensor_sum_two);
					st.reached_one = allow_one && (int'(st.temp_one) >= int'(target_one));
					st.reached_two = allow_two && (int'(st.temp_two) >= int'(target_two));
					st.drive_one   = allow_one && !(int'(st.temp_one) >= int'(target_one));
					st.drive_two   = allow_two && !(int'(st.temp_two) >= int'(target_two));
					status_due.push_back(st);
				end
			end
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$error("status beat arrived with none outstanding");
					n_bad++;
				end else begin
					seen = status_due.pop_front();
					check_field("temp_one", seen.temp_one, temp_one);
					check_field("temp_two", seen.temp_two, temp_two);
					check_field("drive_one", seen.drive_one, drive_one);
					check_field("drive_two", seen.drive_two, drive_two);
					check_field("reached_one", seen.reached_one, reached_one);
					check_field("reached_two", seen.reached_two, reached_two);
				end
			end
			fail_count <= n_bad;
			pending    <= status_due.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-channel thermistor heater. A short
// directed run pins down interpolation corners, then curve reloads, tick
// beats and register settings are mixed under several idling patterns.
// ---------------------------------------------------------------------------
module tb;

	localparam int POST_DRAIN     = 256;    // settle time after each drain
	localparam int HOLD_LEN       = 1500;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 68;

	logic                              clk;
	logic                              arst_n         = 1'b0;
	logic                              cfg_wr_en      = 1'b0;
	logic [thb_pkg::CFG_AW-1:0]        cfg_addr       = '0;
	logic [thb_pkg::CFG_W-1:0]         cfg_wdata      = '0;
	logic                              in_valid       = 1'b0;
	logic                              in_stall;
	logic                              kind           = thb_pkg::KIND_WRITE;
	logic [5:0]                        entry_index    = '0;
	logic [thb_pkg::RAW_W-1:0]         entry_raw      = '0;
	logic signed [thb_pkg::TEMP_W-1:0] entry_temp     = '0;
	logic [thb_pkg::RAW_W-1:0]         sensor_sum_one = '0;
	logic [thb_pkg::RAW_W-1:0]         sensor_sum_two = '0;
	logic                              out_valid;
	logic                              out_stall      = 1'b0;
	logic signed [7:0]                 temp_one, temp_two;
	logic                              drive_one, drive_two, reached_one, reached_two;
	int                                fail_count, pending;

	// Stimulus-side shaping state: the raw column as last written, and the
	// number of entries currently in use.
	int shadow_raw[thb_pkg::TABLE_DEPTH_DEF];
	int live_n = 2;

	// Idle percentages of each side, set per phase by the main sequence.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// Hold-off requests: the main sequence bumps the trigger, the receiver
	// process owns the countdown.
	int hold_trigger = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int quiet        = 0;

	thermistor_bang_bang_heater u_top (.*);

	heater_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long stretch on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_trigger != hold_served) begin
			hold_served = hold_trigger;
			hold_left   = HOLD_LEN - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: count cycles in which no beat and no register write moves.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offer one beat, after a random idle gap, and hold it until accepted.
	task automatic offer_beat(input logic k, input int idx, input int raw, input int tmp,
			input int s1, input int s2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k;
		entry_index    <= 6'(idx);
		entry_raw      <= thb_pkg::RAW_W'(raw);
		entry_temp     <= thb_pkg::TEMP_W'(tmp);
		sensor_sum_one <= thb_pkg::RAW_W'(s1);
		sensor_sum_two <= thb_pkg::RAW_W'(s2);
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Table write; sensor fields carry noise the block must ignore.
	task automatic send_write(input int idx, input int raw, input int tmp);
		shadow_raw[idx] = raw;
		offer_beat(thb_pkg::KIND_WRITE, idx, raw, tmp, $urandom_range(16383),
			$urandom_range(16383));
	endtask

	// Control tick; entry fields carry noise.
	task automatic send_tick(input int s1, input int s2);
		offer_beat(thb_pkg::KIND_TICK, $urandom_range(63), $urandom_range(16383),
			$urandom_range(1535) - 512, s1, s2);
	endtask

	// Drop valid, wait for every outstanding status beat, then let the block settle.
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_reg(input logic [thb_pkg::CFG_AW-1:0] addr, input int data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= thb_pkg::CFG_W'(data);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int clamp_raw(input int v);
		if (v < 0)
			return 0;
		if (v > 16383)
			return 16383;
		return v;
	endfunction

	// Sensor sum: uniform, hugging a live entry, or inside the live span.
	function automatic int pick_sum();
		int j, lo, hi;
		j  = $urandom_range(live_n - 1);
		lo = shadow_raw[0];
		hi = shadow_raw[live_n - 1];
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(16383);
			4, 5, 6, 7: return clamp_raw(shadow_raw[j] + $urandom_range(4) - 2);
			default:    return (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(16383);
		endcase
	endfunction

	// Entry temperature: mostly a plausible range, now and then anywhere.
	function automatic int pick_temp();
		if ($urandom_range(9) < 7)
			return $urandom_range(200) - 50;
		return $urandom_range(1535) - 512;
	endfunction

	// Rewrite one entry, mostly keeping the curve ascending, sometimes breaking it.
	task automatic send_rewrite();
		int idx, lo, hi, raw;
		idx = ($urandom_range(9) < 8) ? $urandom_range(live_n - 1) : $urandom_range(63);
		lo  = (idx > 0)  ? shadow_raw[idx-1] : 0;
		hi  = (idx < 63) ? shadow_raw[idx+1] : 16383;
		case ($urandom_range(19))
			0, 1, 2:    raw = lo;
			3, 4, 5:    raw = $urandom_range(16383);
			default:    raw = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(16383);
		endcase
		send_write(idx, raw, pick_temp());
	endtask

	initial begin
		int entries_by_phase[PHASES];
		int sp1, sp2, n;
		entries_by_phase = '{64, 2, 0, 127, 8, 1, 65, 16, 3, 64, 32, 5};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two-entry curve at reset: extrapolation below the first entry,
		// clamping at the last, and the lower saturation bound.
		send_write(0, 1000, -100);
		send_write(1, 2000, 100);
		send_tick(0, 16383);
		send_tick(1500, 1999);
		send_tick(1000, 999);
		drain(POST_DRAIN);

		// Heaters on, one setpoint at zero and one at the top of its range.
		set_reg(thb_pkg::REG_ENABLE_ONE, 1);
		set_reg(thb_pkg::REG_ENABLE_TWO, 1);
		set_reg(thb_pkg::REG_SETPOINT_ONE, 0);
		set_reg(thb_pkg::REG_SETPOINT_TWO, 32767);
		// Small negative and positive quotients truncate toward zero.
		send_tick(1500, 1499);
		send_tick(1501, 1510);
		// Flat pair: zero span gives the lower temperature.
		send_write(1, 1000, 50);
		send_tick(500, 1000);
		// Descending pair: negative span, extreme temperatures.
		send_write(0, 3000, 1023);
		send_write(1, 100, -512);
		send_tick(50, 8191);
		// Raw extremes across the whole range.
		send_write(0, 0, 1023);
		send_write(1, 16383, -512);
		send_tick(0, 16383);
		drain(POST_DRAIN);
		set_reg(thb_pkg::REG_SETPOINT_ONE, -32768);
		set_reg(thb_pkg::REG_SETPOINT_TWO, -128);
		send_tick(0, 8000);
		send_tick(16383, 12000);

		// Load an ascending curve into every entry before any wider count is used.
		for (int i = 0; i < thb_pkg::TABLE_DEPTH_DEF; i++)
			send_write(i, i * 256 + $urandom_range(200), -60 + i * 4 + $urandom_range(3));

		for (int p = 0; p < PHASES; p++) begin
			drain(POST_DRAIN);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 47; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 47; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			case (p)
				1:       begin sp1 = -32768; sp2 = 32767;  end
				4:       begin sp1 = 32767;  sp2 = -32768; end
				7:       begin sp1 = 127;    sp2 = -128;   end
				default: begin sp1 = $urandom_range(260) - 130; sp2 = $urandom_range(260) - 130; end
			endcase
			// Upper data bits are noise on the narrow registers.
			set_reg(thb_pkg::REG_SETPOINT_ONE, sp1);
			set_reg(thb_pkg::REG_SETPOINT_TWO, sp2);
			set_reg(thb_pkg::REG_ENABLE_ONE, ($urandom_range(511) << 1) | (p[0] ^ p[2]));
			set_reg(thb_pkg::REG_ENABLE_TWO, ($urandom_range(511) << 1) | (p[1] | p[3]));
			set_reg(thb_pkg::REG_TABLE_ENTRIES,
				($urandom_range(511) << 7) | entries_by_phase[p]);
			n = entries_by_phase[p];
			live_n = (n < 2) ? 2 :
				((n > thb_pkg::TABLE_DEPTH_DEF) ? thb_pkg::TABLE_DEPTH_DEF : n);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold the receiver off so the block fills and stalls its input.
				if (p == 2 && i == 20)
					hold_trigger++;
				// Pause the sender until every status beat is home.
				if (p == 5 && i == 40)
					drain(0);
				if ($urandom_range(9) < 2)
					send_rewrite();
				else
					send_tick(pick_sum(), pick_sum());
			end
		end

		drain(POST_DRAIN);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
